/* rtl/pdt_pkg.sv */
// Shared widths, register indexes and reset values for the drive-to-target controller.
package pdt_pkg;

  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CNT_W      = $clog2(GAIN_W);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SPEED_W    = 7;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned HEAD_W     = 16;
  localparam int unsigned ELAPSED_W  = 8;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned HGAIN_W    = 8;
  localparam int unsigned DRIVE_W    = 9;
  localparam int unsigned HDIFF_W    = HEAD_W + 1;
  localparam int unsigned HPROD_W    = HDIFF_W + HGAIN_W + 1;
  localparam int unsigned LSUM_W     = HPROD_W + 1;
  localparam int unsigned NUM_W      = 23;
  localparam int unsigned QUO_W      = 7;
  localparam int unsigned PID_W      = SPEED_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_MS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_MS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN = 3'd7;

  localparam logic KIND_START = 1'b0;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P       = 16'd860;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I       = 16'd0;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D       = 16'd0;
  localparam logic [TIME_W-1:0]  RST_WINDOW       = 16'd30;
  localparam logic [TIME_W-1:0]  RST_RAMP_MS      = 16'd500;
  localparam logic [TIME_W-1:0]  RST_SETTLE_MS    = 16'd100;
  localparam logic [TIME_W-1:0]  RST_TIMEOUT_MS   = 16'd5000;
  localparam logic [HGAIN_W-1:0] RST_HEADING_GAIN = 8'd1;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 9'sd255;

endpackage

/* rtl/pid_drive_to_target.sv */
// Drive-to-target PID controller with bit-serial gain multiplier and ramp divider.
//
// Channels: an input request (kind plus start or tick fields) on in_valid_i/in_ready_o,
// one result request per input on out_valid_o/out_ready_i, and a register write port
// (cfg_index_i, cfg_data_i) that is always ready and must only be used while idle.
// Start requests and ticks with no move armed go from idle straight to the output state.
// A tick of an armed move passes through the error, absolute value and compare steps,
// three passes of the serial multiplier (P, I, D terms, one gain bit per cycle), the
// truncation and clamp, then, while the start ramp is in effect, a restoring divider,
// one quotient bit per cycle, and last the drive step before the output state.
// One request is worked on at a time; the next is accepted once the result has been
// moved to the output register, even if the receiver has not yet taken it.
// If the receiver stalls, the result holds and a finished request waits in its last
// state until the output register is free.
// Reset clears the move state and the result register and restores the register
// defaults; no clearing pass is needed.
module pid_drive_to_target
  import pdt_pkg::*;
#(
  parameter int unsigned POSITION_BITS      = 24,
  parameter int unsigned GAIN_FRACTION_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0]           cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic signed [POSITION_BITS-1:0] target_position_i,
  input  logic [SPEED_W-1:0]              speed_limit_i,
  input  logic [TOL_W-1:0]                tolerance_i,
  input  logic signed [HEAD_W-1:0]        heading_reference_i,
  input  logic [ELAPSED_W-1:0]            elapsed_ms_i,
  input  logic signed [POSITION_BITS-1:0] measured_position_i,
  input  logic signed [HEAD_W-1:0]        measured_heading_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [DRIVE_W-1:0]       left_drive_o,
  output logic signed [DRIVE_W-1:0]       right_drive_o,
  output logic                            on_target_o,
  output logic                            finished_o,
  output logic                            timed_out_o
);

  localparam int unsigned PB    = POSITION_BITS;
  localparam int unsigned FB    = GAIN_FRACTION_BITS;
  localparam int unsigned ERR_W = PB + 1;
  localparam int unsigned DIF_W = PB + 2;
  localparam int unsigned SUM_W = PB + 2;
  localparam int unsigned ACC_W = PB + GAIN_W + 3;
  localparam int unsigned OUT_W = ACC_W - FB;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(GAIN_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

  localparam logic signed [SUM_W-1:0] POS_MAX = {3'b000, {(PB-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] POS_MIN = {3'b111, {(PB-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_ABS, S_CMP, S_MUL_P, S_PTRUNC, S_MUL_I, S_MUL_D,
    S_OTRUNC, S_CLAMP, S_DIV, S_DRIVE, S_OUT
  } state_e;

  state_e state_q;

  // registers
  logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [TIME_W-1:0]  window_q, ramp_q, settle_ms_q, timeout_q;
  logic [HGAIN_W-1:0] hgain_q;

  // move state
  logic                      active_q, inside_q;
  logic signed [PB-1:0]      goal_q, esum_q;
  logic signed [ERR_W-1:0]   prev_q;
  logic [SPEED_W-1:0]        limit_q;
  logic [TOL_W-1:0]          band_q;
  logic signed [HEAD_W-1:0]  hold_q;
  logic [TIME_W-1:0]         move_time_q, settle_time_q;
  logic signed [DRIVE_W-1:0] last_left_q, last_right_q;
  logic                      res_ont_q, res_fin_q, res_tmo_q;
  logic [CNT_W-1:0]          cnt_q;

  // result register
  logic                      out_valid_q;
  logic signed [DRIVE_W-1:0] out_left_q, out_right_q;
  logic                      out_ont_q, out_fin_q, out_tmo_q;

  // datapath
  logic signed [PB-1:0]      pos_q;
  logic signed [HEAD_W-1:0]  head_q;
  logic [ELAPSED_W-1:0]      el_q;
  logic signed [ERR_W-1:0]   err_q;
  logic [ERR_W-1:0]          aerr_q;
  logic signed [DIF_W-1:0]   d_q;
  logic signed [SUM_W-1:0]   sum_raw_q;
  logic signed [HDIFF_W-1:0] hdiff_q;
  logic signed [HPROD_W-1:0] hprod_q;
  logic signed [ACC_W-1:0]   acc_q, mcand_q;
  logic [GAIN_W-1:0]         mplr_q;
  logic signed [OUT_W-1:0]   o_q;
  logic signed [PID_W-1:0]   pid_q;
  logic                      ramp_on_q;
  logic [NUM_W-1:0]          rem_q, dvs_q;
  logic [QUO_W-1:0]          quo_q;

  logic                      in_acc;
  logic                      out_free;
  logic [TIME_W:0]           mt_sum, st_sum;
  logic [TIME_W-1:0]         mt_d, st_d;
  logic signed [ERR_W-1:0]   err_d;
  logic [ERR_W-1:0]          aerr_d;
  logic signed [DIF_W-1:0]   d_d;
  logic signed [SUM_W-1:0]   sum_raw_d, sum_sat;
  logic signed [HPROD_W-1:0] hprod_d;
  logic                      inside_d, win_d;
  logic signed [ACC_W-1:0]   acc_step, acc_fl, acc_tz;
  logic                      acc_adj;
  logic signed [OUT_W-1:0]   lim_ext;
  logic signed [PID_W-1:0]   pid_d, o_fin;
  logic                      goal_neg, goal_pos, ramp_on_d;
  logic [NUM_W-1:0]          mt_ext, num_d;
  logic                      div_ge;
  logic signed [LSUM_W-1:0]  left_sum;
  logic signed [DRIVE_W-1:0] left_sat, left_d, right_d, o_drv;
  logic                      tmo_d, fin_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = out_left_q;
  assign right_drive_o = out_right_q;
  assign on_target_o   = out_ont_q;
  assign finished_o    = out_fin_q;
  assign timed_out_o   = out_tmo_q;

  assign mt_sum = {1'b0, move_time_q} + (TIME_W+1)'(el_q);
  assign st_sum = {1'b0, settle_time_q} + (TIME_W+1)'(el_q);
  assign mt_d   = mt_sum[TIME_W] ? '1 : mt_sum[TIME_W-1:0];
  assign st_d   = st_sum[TIME_W] ? '1 : st_sum[TIME_W-1:0];
  assign err_d  = ERR_W'(goal_q) - ERR_W'(pos_q);

  assign aerr_d    = err_q[ERR_W-1] ? $unsigned(-err_q) : $unsigned(err_q);
  assign d_d       = DIF_W'(err_q) - DIF_W'(prev_q);
  assign sum_raw_d = SUM_W'(esum_q) + SUM_W'(err_q);
  assign hprod_d   = HPROD_W'($signed({1'b0, hgain_q})) * HPROD_W'(hdiff_q);

  assign inside_d = aerr_q <= ERR_W'(band_q);
  assign win_d    = (err_q != '0) && (aerr_q < ERR_W'(window_q));
  assign sum_sat  = (sum_raw_q > POS_MAX) ? POS_MAX :
                    (sum_raw_q < POS_MIN) ? POS_MIN : sum_raw_q;

  assign acc_step = acc_q + (mplr_q[0] ? mcand_q : '0);
  assign acc_fl   = acc_q >>> FB;
  assign acc_adj  = acc_q[ACC_W-1] && (acc_q[FB-1:0] != '0);
  assign acc_tz   = acc_fl + ACC_W'(acc_adj);

  assign lim_ext = $signed(OUT_W'(limit_q));

  always_comb begin
    if (o_q > lim_ext) begin
      pid_d = lim_ext[PID_W-1:0];
    end else if (o_q < -lim_ext) begin
      pid_d = PID_W'(-lim_ext);
    end else begin
      pid_d = o_q[PID_W-1:0];
    end
  end

  assign goal_neg  = goal_q[PB-1];
  assign goal_pos  = !goal_neg && (goal_q != '0);
  assign ramp_on_d = goal_pos && (move_time_q < ramp_q);
  assign mt_ext    = NUM_W'(move_time_q);
  assign num_d     = (mt_ext << 6) + (mt_ext << 5) + (mt_ext << 2);
  assign div_ge    = rem_q >= dvs_q;

  assign o_fin    = ramp_on_q ? $signed({1'b0, quo_q}) : pid_q;
  assign o_drv    = DRIVE_W'(o_fin);
  assign left_sum = LSUM_W'(o_fin) + LSUM_W'(hprod_q);
  assign left_sat = (left_sum > LSUM_W'(DRIVE_MAX))  ? DRIVE_MAX :
                    (left_sum < -LSUM_W'(DRIVE_MAX)) ? -DRIVE_MAX :
                    left_sum[DRIVE_W-1:0];
  assign left_d   = goal_pos ? left_sat : (goal_neg ? o_drv : last_left_q);
  assign right_d  = (goal_pos || goal_neg) ? o_drv : last_right_q;
  assign tmo_d    = move_time_q > timeout_q;
  assign fin_d    = !tmo_d && inside_q && (settle_time_q >= settle_ms_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= RST_GAIN_P;
      gain_i_q    <= RST_GAIN_I;
      gain_d_q    <= RST_GAIN_D;
      window_q    <= RST_WINDOW;
      ramp_q      <= RST_RAMP_MS;
      settle_ms_q <= RST_SETTLE_MS;
      timeout_q   <= RST_TIMEOUT_MS;
      hgain_q     <= RST_HEADING_GAIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GAIN_P:       gain_p_q    <= cfg_data_i;
        REG_GAIN_I:       gain_i_q    <= cfg_data_i;
        REG_GAIN_D:       gain_d_q    <= cfg_data_i;
        REG_WINDOW:       window_q    <= cfg_data_i;
        REG_RAMP_MS:      ramp_q      <= cfg_data_i;
        REG_SETTLE_MS:    settle_ms_q <= cfg_data_i;
        REG_TIMEOUT_MS:   timeout_q   <= cfg_data_i;
        REG_HEADING_GAIN: hgain_q     <= cfg_data_i[HGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      active_q      <= 1'b0;
      inside_q      <= 1'b0;
      goal_q        <= '0;
      esum_q        <= '0;
      prev_q        <= '0;
      limit_q       <= '0;
      band_q        <= '0;
      hold_q        <= '0;
      move_time_q   <= '0;
      settle_time_q <= '0;
      last_left_q   <= '0;
      last_right_q  <= '0;
      res_ont_q     <= 1'b0;
      res_fin_q     <= 1'b0;
      res_tmo_q     <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      out_left_q    <= '0;
      out_right_q   <= '0;
      out_ont_q     <= 1'b0;
      out_fin_q     <= 1'b0;
      out_tmo_q     <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_ont_q <= 1'b0;
            res_fin_q <= 1'b0;
            res_tmo_q <= 1'b0;
            if (kind_i == KIND_START) begin
              goal_q        <= target_position_i;
              limit_q       <= speed_limit_i;
              band_q        <= tolerance_i;
              hold_q        <= heading_reference_i;
              move_time_q   <= '0;
              settle_time_q <= '0;
              esum_q        <= '0;
              prev_q        <= '0;
              inside_q      <= 1'b0;
              active_q      <= 1'b1;
              state_q       <= S_OUT;
            end else if (active_q) begin
              state_q <= S_ERR;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_ERR: begin
          move_time_q   <= mt_d;
          settle_time_q <= st_d;
          state_q       <= S_ABS;
        end
        S_ABS: begin
          prev_q  <= err_q;
          state_q <= S_CMP;
        end
        S_CMP: begin
          inside_q <= inside_d;
          if (!inside_d) begin
            settle_time_q <= '0;
          end
          esum_q  <= win_d ? sum_sat[PB-1:0] : '0;
          cnt_q   <= '0;
          state_q <= S_MUL_P;
        end
        S_MUL_P: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == MUL_LAST) begin
            state_q <= S_PTRUNC;
          end
        end
        S_PTRUNC: begin
          cnt_q   <= '0;
          state_q <= S_MUL_I;
        end
        S_MUL_I: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == MUL_LAST) begin
            state_q <= S_MUL_D;
          end
        end
        S_MUL_D: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == MUL_LAST) begin
            state_q <= S_OTRUNC;
          end
        end
        S_OTRUNC: begin
          state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          cnt_q   <= '0;
          state_q <= ramp_on_d ? S_DIV : S_DRIVE;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_LAST) begin
            state_q <= S_DRIVE;
          end
        end
        S_DRIVE: begin
          res_ont_q <= inside_q;
          res_fin_q <= fin_d;
          res_tmo_q <= tmo_d;
          if (tmo_d || fin_d) begin
            last_left_q  <= '0;
            last_right_q <= '0;
            active_q     <= 1'b0;
          end else begin
            last_left_q  <= left_d;
            last_right_q <= right_d;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_left_q  <= last_left_q;
            out_right_q <= last_right_q;
            out_ont_q   <= res_ont_q;
            out_fin_q   <= res_fin_q;
            out_tmo_q   <= res_tmo_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        pos_q  <= measured_position_i;
        head_q <= measured_heading_i;
        el_q   <= elapsed_ms_i;
      end
      S_ERR: begin
        err_q   <= err_d;
        hdiff_q <= HDIFF_W'(hold_q) - HDIFF_W'(head_q);
      end
      S_ABS: begin
        aerr_q    <= aerr_d;
        d_q       <= d_d;
        sum_raw_q <= sum_raw_d;
        hprod_q   <= hprod_d;
      end
      S_CMP: begin
        acc_q   <= '0;
        mcand_q <= ACC_W'(err_q);
        mplr_q  <= gain_p_q;
      end
      S_MUL_P: begin
        acc_q   <= acc_step;
        mcand_q <= mcand_q <<< 1;
        mplr_q  <= mplr_q >> 1;
      end
      S_PTRUNC: begin
        acc_q   <= acc_tz <<< FB;
        mcand_q <= ACC_W'(esum_q);
        mplr_q  <= gain_i_q;
      end
      S_MUL_I: begin
        acc_q <= acc_step;
        if (cnt_q == MUL_LAST) begin
          mcand_q <= ACC_W'(d_q);
          mplr_q  <= gain_d_q;
        end else begin
          mcand_q <= mcand_q <<< 1;
          mplr_q  <= mplr_q >> 1;
        end
      end
      S_MUL_D: begin
        acc_q   <= acc_step;
        mcand_q <= mcand_q <<< 1;
        mplr_q  <= mplr_q >> 1;
      end
      S_OTRUNC: begin
        o_q <= acc_tz[OUT_W-1:0];
      end
      S_CLAMP: begin
        pid_q     <= pid_d;
        ramp_on_q <= ramp_on_d;
        rem_q     <= num_d;
        dvs_q     <= {1'b0, ramp_q, 6'b0};
        quo_q     <= '0;
      end
      S_DIV: begin
        if (div_ge) begin
          rem_q <= rem_q - dvs_q;
        end
        dvs_q <= dvs_q >> 1;
        quo_q <= {quo_q[QUO_W-2:0], div_ge};
      end
      default: ;
    endcase
  end

endmodule

/* rtl/pdt_checker.sv */
// Port-level checks on the drive-to-target controller's result channel, bound to the top level.
module pdt_checker
  import pdt_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [DRIVE_W-1:0] left_drive_o,
  input logic signed [DRIVE_W-1:0] right_drive_o,
  input logic                      on_target_o,
  input logic                      finished_o,
  input logic                      timed_out_o
);

  localparam logic [DRIVE_W-1:0] DRIVE_NEG_END = {1'b1, {(DRIVE_W-1){1'b0}}};

  // end of move forces the wheels to stop
  a_stop_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (finished_o || timed_out_o) |-> left_drive_o == '0 && right_drive_o == '0)
    else $error("drives not zero at end of move");

  a_one_ending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(finished_o && timed_out_o))
    else $error("finished and timed out together");

  a_fin_in_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> on_target_o)
    else $error("finished while outside tolerance");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_drive_o != DRIVE_NEG_END && right_drive_o != DRIVE_NEG_END)
    else $error("drive outside saturation range");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_drive_o)
      && $stable(right_drive_o))
    else $error("stalled result request changed");

endmodule

bind pid_drive_to_target pdt_checker u_pdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .left_drive_o  (left_drive_o),
  .right_drive_o (right_drive_o),
  .on_target_o   (on_target_o),
  .finished_o    (finished_o),
  .timed_out_o   (timed_out_o)
);

/* bench/pid_drive_to_target_tb.sv */
// Self-checking testbench for the drive-to-target PID controller.
module pid_drive_to_target_tb
  import pdt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POS_W       = 24;
  localparam int unsigned FRAC_W      = 12;
  localparam longint      FRAC_ONE    = longint'(1) << FRAC_W;
  localparam longint      SUM_HI      = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint      SUM_LO      = -SUM_HI - 1;
  localparam longint      DRIVE_LIM   = 255;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic        KIND_TICK   = ~KIND_START;

  localparam logic signed [POS_W-1:0]  POS_HI  = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]  POS_LO  = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [HEAD_W-1:0] HEAD_HI = 16'sh7FFF;
  localparam logic signed [HEAD_W-1:0] HEAD_LO = 16'sh8000;

  typedef struct packed {
    logic                       kind;
    logic signed [POS_W-1:0]    target;
    logic [SPEED_W-1:0]         speed;
    logic [TOL_W-1:0]           tol;
    logic signed [HEAD_W-1:0]   href;
    logic [ELAPSED_W-1:0]       elapsed;
    logic signed [POS_W-1:0]    pos;
    logic signed [HEAD_W-1:0]   head;
  } move_req_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
    logic                      on_target;
    logic                      finished;
    logic                      timed_out;
  } drive_res_t;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  move_req_t              in_req    = '0;
  logic                   out_ready = 1'b0;

  logic                      cfg_ready;
  logic                      in_ready;
  logic                      out_valid;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;
  logic                      on_target;
  logic                      finished;
  logic                      timed_out;

  // shadow registers
  logic [GAIN_W-1:0]  kp          = RST_GAIN_P;
  logic [GAIN_W-1:0]  ki          = RST_GAIN_I;
  logic [GAIN_W-1:0]  kd          = RST_GAIN_D;
  logic [TIME_W-1:0]  win         = RST_WINDOW;
  logic [TIME_W-1:0]  ramp_len    = RST_RAMP_MS;
  logic [TIME_W-1:0]  settle_need = RST_SETTLE_MS;
  logic [TIME_W-1:0]  timeout_lim = RST_TIMEOUT_MS;
  logic [HGAIN_W-1:0] head_gain   = RST_HEADING_GAIN;

  // shadow move state
  logic                      armed      = 1'b0;
  logic signed [POS_W-1:0]   goal       = '0;
  logic [SPEED_W-1:0]        speed_cap  = '0;
  logic [TOL_W-1:0]          band       = '0;
  logic signed [HEAD_W-1:0]  hold_head  = '0;
  logic signed [POS_W-1:0]   err_sum    = '0;
  logic signed [POS_W:0]     prev_err   = '0;
  logic [TIME_W-1:0]         move_ms    = '0;
  logic [TIME_W-1:0]         settle_cnt = '0;
  logic signed [DRIVE_W-1:0] last_left  = '0;
  logic signed [DRIVE_W-1:0] last_right = '0;

  move_req_t  move_reqs[$];
  drive_res_t due_drives[$];
  move_req_t  nxt_req;
  drive_res_t want;

  logic        req_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned n_cycles  = 0;
  int          n_pushed  = 0;
  int          n_results = 0;
  int          n_fail    = 0;
  int          n_starts  = 0;
  int          n_ticks   = 0;
  int          n_writes  = 0;
  int          n_settled = 0;
  int          n_aborted = 0;
  int          n_ontgt   = 0;

  pid_drive_to_target #(
    .POSITION_BITS      (POS_W),
    .GAIN_FRACTION_BITS (FRAC_W)
  ) uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .kind_i              (in_req.kind),
    .target_position_i   (in_req.target),
    .speed_limit_i       (in_req.speed),
    .tolerance_i         (in_req.tol),
    .heading_reference_i (in_req.href),
    .elapsed_ms_i        (in_req.elapsed),
    .measured_position_i (in_req.pos),
    .measured_heading_i  (in_req.head),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .left_drive_o        (left_drive),
    .right_drive_o       (right_drive),
    .on_target_o         (on_target),
    .finished_o          (finished),
    .timed_out_o         (timed_out)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void write_shadow(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_GAIN_P:       kp          = data;
      REG_GAIN_I:       ki          = data;
      REG_GAIN_D:       kd          = data;
      REG_WINDOW:       win         = data;
      REG_RAMP_MS:      ramp_len    = data;
      REG_SETTLE_MS:    settle_need = data;
      REG_TIMEOUT_MS:   timeout_lim = data;
      REG_HEADING_GAIN: head_gain   = data[HGAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // Wheel commands for one request; updates the shadow move state.
  function automatic drive_res_t next_drive(input move_req_t r);
    drive_res_t res;
    longint     err, aerr, sum, dlt, prop, pid, lim, lft, rgt, mt, st;
    res = '0;
    lft = last_left;
    rgt = last_right;
    if (r.kind == KIND_START) begin
      goal       = r.target;
      speed_cap  = r.speed;
      band       = r.tol;
      hold_head  = r.href;
      move_ms    = '0;
      settle_cnt = '0;
      err_sum    = '0;
      prev_err   = '0;
      armed      = 1'b1;
      n_starts++;
    end else begin
      n_ticks++;
      if (armed) begin
        mt = longint'(move_ms) + longint'(r.elapsed);
        st = longint'(settle_cnt) + longint'(r.elapsed);
        move_ms = (mt > 65535) ? 16'hFFFF : mt[15:0];
        err  = longint'(goal) - longint'(r.pos);
        aerr = (err < 0) ? -err : err;
        res.on_target = (aerr <= longint'(band));
        if (!res.on_target) st = 0;
        settle_cnt = (st > 65535) ? 16'hFFFF : st[15:0];

        // integral only inside the window, cleared otherwise
        if (err != 0 && aerr < longint'(win)) sum = clip(longint'(err_sum) + err, SUM_LO, SUM_HI);
        else sum = 0;
        err_sum = sum[POS_W-1:0];
        dlt = err - longint'(prev_err);
        prev_err = err[POS_W:0];

        prop = err * longint'(kp) / FRAC_ONE;
        pid  = (prop * FRAC_ONE + sum * longint'(ki) + dlt * longint'(kd)) / FRAC_ONE;
        lim  = longint'(speed_cap);
        pid  = clip(pid, -lim, lim);
        if (goal > 0 && longint'(move_ms) < longint'(ramp_len))
          pid = 100 * longint'(move_ms) / longint'(ramp_len);

        if (goal > 0) begin
          lft = pid + longint'(head_gain) * (longint'(hold_head) - longint'(r.head));
          rgt = pid;
        end else if (goal < 0) begin
          lft = pid;
          rgt = pid;
        end
        lft = clip(lft, -DRIVE_LIM, DRIVE_LIM);
        rgt = clip(rgt, -DRIVE_LIM, DRIVE_LIM);

        if (move_ms > timeout_lim) res.timed_out = 1'b1;
        else if (res.on_target && settle_cnt >= settle_need) res.finished = 1'b1;
        if (res.timed_out || res.finished) begin
          lft   = 0;
          rgt   = 0;
          armed = 1'b0;
        end
        last_left  = lft[DRIVE_W-1:0];
        last_right = rgt[DRIVE_W-1:0];
      end
    end
    res.left  = lft[DRIVE_W-1:0];
    res.right = rgt[DRIVE_W-1:0];
    return res;
  endfunction

  function automatic move_req_t start_req(input logic signed [POS_W-1:0] tgt,
                                          input logic [SPEED_W-1:0] spd,
                                          input logic [TOL_W-1:0] tol,
                                          input logic signed [HEAD_W-1:0] href);
    move_req_t r;
    r.kind    = KIND_START;
    r.target  = tgt;
    r.speed   = spd;
    r.tol     = tol;
    r.href    = href;
    r.elapsed = ELAPSED_W'($urandom);
    r.pos     = POS_W'($urandom);
    r.head    = HEAD_W'($urandom);
    return r;
  endfunction

  function automatic move_req_t tick_req(input logic [ELAPSED_W-1:0] el,
                                         input logic signed [POS_W-1:0] pos,
                                         input logic signed [HEAD_W-1:0] head);
    move_req_t r;
    r.kind    = KIND_TICK;
    r.target  = POS_W'($urandom);
    r.speed   = SPEED_W'($urandom);
    r.tol     = TOL_W'($urandom);
    r.href    = HEAD_W'($urandom);
    r.elapsed = el;
    r.pos     = pos;
    r.head    = head;
    return r;
  endfunction

  function automatic move_req_t noise_req();
    move_req_t r;
    r = tick_req(ELAPSED_W'($urandom), POS_W'($urandom), HEAD_W'($urandom));
    r.kind = 1'($urandom);
    return r;
  endfunction

  function automatic void add_req(input move_req_t r);
    move_reqs.push_back(r);
    n_pushed++;
  endfunction

  task automatic check_field(input string name, input integer want_v, input integer got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      n_fail++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk_i);
    while (!cfg_taken) @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                           input logic [15:0] w, input logic [15:0] ramp,
                           input logic [15:0] settle, input logic [15:0] tmo,
                           input logic [15:0] hg);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_WINDOW, w);
    write_reg(REG_RAMP_MS, ramp);
    write_reg(REG_SETTLE_MS, settle);
    write_reg(REG_TIMEOUT_MS, tmo);
    write_reg(REG_HEADING_GAIN, hg);
  endtask

  task automatic drain();
    while (n_results < n_pushed) @(negedge clk_i);
  endtask

  // Mostly whole moves that close in on the target, with stray requests mixed in.
  task automatic random_moves(input int n);
    int                       stop_at, ticks, pick;
    longint                   tgt, err;
    logic signed [POS_W-1:0]  raw;
    logic signed [HEAD_W-1:0] href, head;
    logic [ELAPSED_W-1:0]     el;
    stop_at = n_pushed + n;
    while (n_pushed < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        case ($urandom_range(9))
          0: tgt = 0;
          1: begin
            raw = POS_W'($urandom);
            tgt = raw;
          end
          2, 3, 4, 5: tgt = $urandom_range(3000, 1);
          default: tgt = -longint'($urandom_range(3000, 1));
        endcase
        href = ($urandom_range(7) == 0) ? HEAD_W'($urandom)
                                        : HEAD_W'(int'($urandom_range(720)) - 360);
        add_req(start_req(POS_W'(tgt),
                          ($urandom_range(9) == 0) ? SPEED_W'($urandom_range(127, 101))
                                                   : SPEED_W'($urandom_range(100)),
                          ($urandom_range(7) == 0) ? TOL_W'($urandom)
                                                   : TOL_W'($urandom_range(40)),
                          href));
        ticks = $urandom_range(30, 3);
        err = tgt;
        for (int k = 0; k < ticks; k++) begin
          if ($urandom_range(4) != 0)
            err = err - err / longint'($urandom_range(5, 2)) + longint'($urandom_range(6)) - 3;
          el = ($urandom_range(9) == 0) ? ELAPSED_W'($urandom)
                                        : ELAPSED_W'($urandom_range(40));
          head = ($urandom_range(9) == 0) ? HEAD_W'($urandom)
                                          : HEAD_W'(longint'(href) + $urandom_range(20) - 10);
          add_req(tick_req(el, POS_W'(tgt - err), head));
        end
      end else if (pick < 90) begin
        add_req(noise_req());
      end else begin
        add_req(start_req(POS_W'($urandom), SPEED_W'($urandom), TOL_W'($urandom),
                          HEAD_W'($urandom)));
      end
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || req_taken) begin
        if (move_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt_req = move_reqs.pop_front();
          in_req   <= nxt_req;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // result monitor and prediction
  always @(posedge clk_i) begin
    req_taken <= in_valid && in_ready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        write_shadow(cfg_index, cfg_data);
        n_writes++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (due_drives.size() == 0) begin
          $display("%0t: unexpected result, got left %0d right %0d on %0b fin %0b tmo %0b",
                   $time, left_drive, right_drive, on_target, finished, timed_out);
          n_fail++;
        end else begin
          want = due_drives.pop_front();
          check_field("left_drive", want.left, left_drive);
          check_field("right_drive", want.right, right_drive);
          check_field("on_target", want.on_target, on_target);
          check_field("finished", want.finished, finished);
          check_field("timed_out", want.timed_out, timed_out);
          n_settled += want.finished;
          n_aborted += want.timed_out;
          n_ontgt   += want.on_target;
        end
      end
      if (in_valid && in_ready) due_drives.push_back(next_drive(in_req));
    end
  end

  always @(posedge clk_i) n_cycles <= n_cycles + 1;

  initial begin
    wait (n_cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d of %0d results seen", n_cycles, n_results,
             n_pushed);
    $display("pid_drive_to_target verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 38;
    recv_idle = 79;

    // reset register values
    add_req(tick_req(8'd255, POS_LO, HEAD_LO));           // tick with no move
    add_req(start_req(24'sd1000, 7'd127, 16'd0, HEAD_HI));
    add_req(tick_req(8'd255, 24'sd0, HEAD_LO));           // ramp, left saturates
    add_req(tick_req(8'd255, POS_HI, HEAD_HI));
    add_req(tick_req(8'd0, 24'sd1000, 16'sd0));
    add_req(tick_req(8'd100, 24'sd1000, 16'sd0));         // settles
    add_req(tick_req(8'd17, 24'sd55, 16'sd3));
    add_req(start_req(POS_LO, 7'd100, 16'hFFFF, HEAD_LO));
    add_req(tick_req(8'd1, POS_HI, 16'sd0));
    add_req(tick_req(8'd60, POS_LO + 24'sd8, 16'sd0));
    add_req(tick_req(8'd60, POS_LO, 16'sd0));
    add_req(start_req(-24'sd500, 7'd80, 16'd5, 16'sd0));
    add_req(tick_req(8'd10, 24'sd0, 16'sd0));
    add_req(start_req(24'sd0, 7'd50, 16'd10, 16'sd0));    // zero target keeps drives
    add_req(tick_req(8'd10, 24'sd7, 16'sd0));
    add_req(start_req(POS_HI, 7'd0, 16'hFFFF, 16'sd0));
    add_req(tick_req(8'd255, POS_LO, HEAD_HI));
    add_req(tick_req(8'd255, POS_LO, HEAD_LO));
    add_req(tick_req(8'd255, POS_HI, 16'sd0));
    drain();

    // gains at full scale, no ramp, instant timeout
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hA5FF);
    add_req(start_req(24'sd20000, 7'd127, 16'd100, HEAD_LO));
    add_req(tick_req(8'd0, 24'sd19990, HEAD_HI));
    add_req(tick_req(8'd0, 24'sd20010, 16'sd0));
    add_req(tick_req(8'd1, 24'sd0, 16'sd0));               // times out
    add_req(start_req(-24'sd1, 7'd0, 16'd0, 16'sd0));
    add_req(tick_req(8'd0, -24'sd1, 16'sd0));
    add_req(tick_req(8'd0, POS_HI, 16'sd0));
    add_req(tick_req(8'd255, 24'sd0, 16'sd0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'h00FF);
        3: load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'd0);
        default: load_regs(16'($urandom_range(8192, 400)), 16'($urandom_range(400)),
                           16'($urandom_range(2000)), 16'($urandom_range(600)),
                           16'($urandom_range(800, 1)), 16'($urandom_range(300)),
                           16'($urandom_range(6000, 300)), 16'($urandom_range(6)));
      endcase
      if (ph == 2) begin
        send_idle = 79;
        recv_idle = 38;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_moves(240);
      drain();
    end

    repeat (80) @(negedge clk_i);
    $display("covered %0d requests (%0d move starts, %0d ticks) over %0d register writes",
             n_pushed, n_starts, n_ticks, n_writes);
    $display("%0d results checked: %0d on target, %0d settled, %0d timed out",
             n_results, n_ontgt, n_settled, n_aborted);
    if (n_fail == 0 && due_drives.size() == 0) begin
      $display("pid_drive_to_target verification clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_fail, due_drives.size());
      $display("pid_drive_to_target verification failed");
    end
    $finish;
  end

endmodule
